[sv/kehid_pkg.sv]
`default_nettype none

package kehid_pkg;

    localparam logic [3:0] MOD_CTRL  = 4'h1;
    localparam logic [3:0] MOD_SHIFT = 4'h2;
    localparam logic [3:0] MOD_ALT   = 4'h4;
    localparam logic [3:0] MOD_META  = 4'h8;

    localparam logic [7:0] HID_LCTRL  = 8'hE0;
    localparam logic [7:0] HID_LSHIFT = 8'hE1;
    localparam logic [7:0] HID_LALT   = 8'hE2;
    localparam logic [7:0] HID_LMETA  = 8'hE3;

    localparam logic [7:0] HID_LETTER_FIRST = 8'h04;
    localparam logic [7:0] HID_LETTER_LAST  = 8'h1D;
    localparam logic [7:0] HID_MOD_LSHIFT   = 8'h02;

    localparam int unsigned LAYOUT_ROWS = 4;
    localparam int unsigned LAYOUT_COLS = 14;
    localparam int unsigned MATRIX_ROWS = 7;
    localparam int unsigned MATRIX_COLS = 8;

    localparam logic [7:0] PLAIN_LAYER [LAYOUT_ROWS][LAYOUT_COLS] = '{
        '{8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
          8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A},
        '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
          8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31},
        '{8'h00, 8'hE1, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A,
          8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28},
        '{8'hE0, 8'hE3, 8'hE2, 8'h1D, 8'h1B, 8'h06, 8'h19,
          8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h2C}};

    localparam logic [7:0] FN_LAYER [LAYOUT_ROWS][LAYOUT_COLS] = '{
        '{8'h29, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h4C},
        '{8'h00, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
          8'h18, 8'h0C, 8'h12, 8'h13, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A,
          8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h52, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h1D, 8'h1B, 8'h06, 8'h19,
          8'h05, 8'h11, 8'h10, 8'h50, 8'h51, 8'h4F, 8'h00}};

    typedef struct packed {
        logic       event_valid;
        logic       pressed;
        logic [1:0] layout_row;
        logic [3:0] layout_col;
        logic [7:0] key_code;
        logic       is_modifier;
        logic [7:0] extra_modifiers;
        logic [3:0] modifier_bits;
        logic       fn_held;
    } t_result;

    typedef struct packed {
        logic [3:0] modifiers;
        logic       fn_flag;
    } t_mod_state;

endpackage

`default_nettype wire

[sv/key_event_to_hid_translator.sv]
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while i_out_ready does not stall
// the output; held modifier and Fn state update as the input register hands
// its event to the result register.
// Reset (synchronous, active low) empties both registers and clears the
// held modifiers and Fn flag.
`default_nettype none

module key_event_to_hid_translator
    import kehid_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_event_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_event_valid,
    output logic            o_pressed,
    output logic [1:0]      o_layout_row,
    output logic [3:0]      o_layout_col,
    output logic [7:0]      o_key_code,
    output logic            o_is_modifier,
    output logic [7:0]      o_extra_modifiers,
    output logic [3:0]      o_modifier_bits,
    output logic            o_fn_held
);

    logic       r_in_valid;
    logic [7:0] r_event_byte;
    logic       r_out_valid;
    t_result    r_result;
    t_mod_state r_state;
    t_mod_state n_state;
    t_result    n_result;
    logic       out_free;
    logic       advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    kehid_decode u_decode (
        .i_event_byte (r_event_byte),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_event_byte <= i_event_byte;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_valid     = r_result.event_valid;
    assign o_pressed         = r_result.pressed;
    assign o_layout_row      = r_result.layout_row;
    assign o_layout_col      = r_result.layout_col;
    assign o_key_code        = r_result.key_code;
    assign o_is_modifier     = r_result.is_modifier;
    assign o_extra_modifiers = r_result.extra_modifiers;
    assign o_modifier_bits   = r_result.modifier_bits;
    assign o_fn_held         = r_result.fn_held;

endmodule

`default_nettype wire

[sv/kehid_decode.sv]
`default_nettype none

module kehid_decode
    import kehid_pkg::*;
(
    input  wire logic [7:0] i_event_byte,
    input  wire t_mod_state i_state,
    output t_mod_state      o_next_state,
    output t_result         o_result
);

    logic [6:0]  num;
    logic [6:0]  nm1;
    logic [14:0] prod;
    logic [3:0]  mrow;
    logic [7:0]  row_x10;
    logic [3:0]  mcol;
    logic        in_range;
    logic [1:0]  lrow;
    logic [3:0]  lcol;
    logic        press;
    logic [7:0]  plain_code;
    logic [7:0]  fn_code;
    logic        is_fn_key;

    always_comb begin
        press   = i_event_byte[7];
        num     = i_event_byte[6:0];
        nm1     = num - 7'd1;
        // divide by ten through reciprocal, exact for this range
        prod    = {8'd0, nm1} * 15'd205;
        mrow    = prod[14:11];
        row_x10 = {4'd0, mrow} * 8'd10;
        mcol    = 4'(({1'b0, nm1} - row_x10));
        in_range = (num != 7'd0) && (mrow < 4'(MATRIX_ROWS)) && (mcol < 4'(MATRIX_COLS));
        lrow    = mcol[1:0];
        lcol    = 4'({mrow[2:0], 1'b0} + {3'd0, (mcol > 4'd3)});

        plain_code = PLAIN_LAYER[lrow][lcol];
        fn_code    = FN_LAYER[lrow][lcol];
        is_fn_key  = (lrow == 2'd2) && (lcol == 4'd0);

        o_next_state = i_state;
        if (in_range) begin
            if (lrow == 2'd3 && lcol == 4'd0) begin
                o_next_state.modifiers = press ? (i_state.modifiers | MOD_CTRL)
                                               : (i_state.modifiers & ~MOD_CTRL);
            end
            if (lrow == 2'd2 && lcol == 4'd1) begin
                o_next_state.modifiers = press ? (i_state.modifiers | MOD_SHIFT)
                                               : (i_state.modifiers & ~MOD_SHIFT);
            end
            if (lrow == 2'd3 && lcol == 4'd2) begin
                o_next_state.modifiers = press ? (i_state.modifiers | MOD_ALT)
                                               : (i_state.modifiers & ~MOD_ALT);
            end
            if (lrow == 2'd3 && lcol == 4'd1) begin
                o_next_state.modifiers = press ? (i_state.modifiers | MOD_META)
                                               : (i_state.modifiers & ~MOD_META);
            end
            if (is_fn_key) begin
                o_next_state.fn_flag = press;
            end
        end

        o_result                 = '0;
        o_result.pressed         = press;
        o_result.modifier_bits   = o_next_state.modifiers;
        o_result.fn_held         = o_next_state.fn_flag;
        if (in_range) begin
            o_result.event_valid = 1'b1;
            o_result.layout_row  = lrow;
            o_result.layout_col  = lcol;
            if (is_fn_key) begin
                o_result.is_modifier = 1'b1;
            end else if (o_next_state.fn_flag && fn_code != 8'd0) begin
                o_result.key_code = fn_code;
                if (fn_code >= HID_LETTER_FIRST && fn_code <= HID_LETTER_LAST) begin
                    o_result.extra_modifiers = HID_MOD_LSHIFT;
                end
            end else begin
                o_result.key_code    = plain_code;
                o_result.is_modifier = (plain_code == HID_LSHIFT) || (plain_code == HID_LCTRL)
                                    || (plain_code == HID_LALT) || (plain_code == HID_LMETA);
            end
        end
    end

endmodule

`default_nettype wire

[sv/kehid_checker.sv]
`default_nettype none

module kehid_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_event_valid,
    input wire logic [1:0] o_layout_row,
    input wire logic [3:0] o_layout_col,
    input wire logic [7:0] o_key_code,
    input wire logic       o_is_modifier,
    input wire logic [7:0] o_extra_modifiers,
    input wire logic       o_fn_held
);

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_event_valid |-> o_layout_row == 2'd0 && o_layout_col == 4'd0
            && o_key_code == 8'd0 && !o_is_modifier && o_extra_modifiers == 8'd0)
        else $error("invalid event carries nonzero fields");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_valid |-> o_layout_col <= 4'd13)
        else $error("layout column out of range");

    a_extra_fn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_extra_modifiers != 8'd0 |-> o_fn_held && !o_is_modifier)
        else $error("extra modifiers without Fn layer");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key_code)
            && $stable(o_layout_col))
        else $error("stalled result changed");

endmodule

bind key_event_to_hid_translator kehid_checker u_kehid_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_event_valid     (o_event_valid),
    .o_layout_row      (o_layout_row),
    .o_layout_col      (o_layout_col),
    .o_key_code        (o_key_code),
    .o_is_modifier     (o_is_modifier),
    .o_extra_modifiers (o_extra_modifiers),
    .o_fn_held         (o_fn_held)
);

`default_nettype wire
